// File: sv/bcmp_pkg.sv
package bcmp_pkg;

  localparam int unsigned RES_W = 30;
  localparam int unsigned IDX_W = 15;
  localparam int unsigned MUL_LAT = 4;

  localparam logic [29:0] PRIME = 30'd998244353;
  localparam logic [29:0] PRIME_EXP = 30'd998244351;
  localparam logic [31:0] PRIME_X1 = 32'd998244353;
  localparam logic [31:0] PRIME_X2 = 32'd1996488706;
  localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0] MU = MU_WIDE[30:0];

  typedef struct packed {
    logic             oor;
    logic             zero;
    logic [IDX_W-1:0] am;
    logic [IDX_W-1:0] an;
    logic [IDX_W-1:0] ad;
  } qry_t;

endpackage

// File: sv/bcmp_mulmod.sv
module bcmp_mulmod (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [29:0] a,
  input  logic [29:0] b,
  output logic        out_valid,
  output logic [29:0] r
);
  import bcmp_pkg::*;

  logic [3:0]  v;
  logic [59:0] prod;
  logic [59:0] prod2;
  logic [61:0] q2;
  logic [31:0] r3;
  logic [29:0] res;
  logic [60:0] qp;

  // barrett estimate leaves the remainder below three times the prime
  assign qp = q2[61:31] * PRIME;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], in_valid};
    end
    prod  <= a * b;
    q2    <= prod[59:29] * MU;
    prod2 <= prod;
    r3    <= prod2[31:0] - qp[31:0];
    if (r3 >= PRIME_X2) begin
      res <= 30'(r3 - PRIME_X2);
    end else if (r3 >= PRIME_X1) begin
      res <= 30'(r3 - PRIME_X1);
    end else begin
      res <= r3[29:0];
    end
  end

  assign out_valid = v[3];
  assign r = res;
endmodule

// File: sv/bcmp_front.sv
module bcmp_front #(
  parameter int unsigned TABLE_MAX = 1023
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // top_count [15:0], choose_count [31:16]
  output logic             q_valid,
  output bcmp_pkg::qry_t   q_data,
  input  logic             q_ready
);
  import bcmp_pkg::*;

  localparam int unsigned QD = 4;

  logic [15:0] m;
  logic [15:0] n;
  logic [15:0] diff;
  logic signed [31:0] m_ext;
  qry_t cls;
  qry_t qmem [QD];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic push;
  logic pop;

  assign m = s_tdata[15:0];
  assign n = s_tdata[31:16];
  assign diff = m - n;
  assign m_ext = {{16{m[15]}}, m};

  always_comb begin
    cls.oor  = m_ext > $signed(32'(TABLE_MAX));
    cls.zero = m[15] | n[15] | ($signed(m) < $signed(n));
    cls.am   = m[IDX_W-1:0];
    cls.an   = n[IDX_W-1:0];
    cls.ad   = diff[IDX_W-1:0];
  end

  assign s_tready = count != 3'(QD);
  assign push = s_tvalid & s_tready;
  assign q_valid = count != '0;
  assign q_data = qmem[rd_ptr];
  assign pop = q_valid & q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
    if (push) qmem[wr_ptr] <= cls;
  end
endmodule

// File: sv/bcmp_back.sv
module bcmp_back #(
  parameter int unsigned TABLE_MAX = 1023
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bcmp_pkg::qry_t   q_data,
  output logic             q_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,   // coefficient [29:0], zero pad [31:30]
  output logic             m_tuser    // out_of_range
);
  import bcmp_pkg::*;

  localparam int unsigned AW = (TABLE_MAX < 2) ? 1 : $clog2(TABLE_MAX + 1);
  localparam int unsigned DEPTH = TABLE_MAX + 1;
  localparam int unsigned OD = 16;
  localparam logic [AW-1:0] TMAX = AW'(TABLE_MAX);

  typedef enum logic [2:0] {S_INIT, S_FACT, S_PMUL, S_PSQR, S_INV, S_DONE} st_t;

  st_t state;
  logic waiting;
  logic [AW-1:0] idx;
  logic [29:0] acc;
  logic [29:0] pacc;
  logic [29:0] base;
  logic [29:0] expo;

  logic mb_go;
  logic mb_v;
  logic [29:0] mb_a;
  logic [29:0] mb_b;
  logic [29:0] mb_r;

  logic fw_en;
  logic [AW-1:0] fw_addr;
  logic [29:0] fw_data;
  logic iw_en;
  logic [AW-1:0] iw_addr;
  logic [29:0] iw_data;

  logic [29:0] fact_mem [DEPTH];
  logic [29:0] inv_mem [DEPTH];

  logic issue;
  logic [4:0] credit;
  logic v0;
  logic [1:0] f0;
  logic [29:0] fm_rd;
  logic [29:0] in_rd;
  logic [29:0] id_rd;
  logic [29:0] id_dly [MUL_LAT];
  logic [1:0] fl_dly [2*MUL_LAT];
  logic m1_v;
  logic [29:0] m1_r;
  logic m2_v;
  logic [29:0] m2_r;

  logic [30:0] omem [OD];
  logic [3:0] owr;
  logic [3:0] ord;
  logic [4:0] ocount;
  logic opop;
  logic [1:0] fl_out;

  // build sequencer operand selection
  always_comb begin
    mb_a = acc;
    mb_b = 30'(idx);
    mb_go = 1'b0;
    case (state)
      S_FACT, S_INV: mb_go = !waiting;
      S_PMUL: begin
        mb_a = pacc;
        mb_b = base;
        mb_go = !waiting && (expo != '0) && expo[0];
      end
      S_PSQR: begin
        mb_a = base;
        mb_b = base;
        mb_go = !waiting;
      end
      default: mb_go = 1'b0;
    endcase
  end

  always_comb begin
    fw_en   = (state == S_INIT) || (state == S_FACT && waiting && mb_v);
    fw_addr = (state == S_INIT) ? '0 : idx;
    fw_data = (state == S_INIT) ? 30'd1 : mb_r;
    iw_en   = (state == S_PMUL && !waiting && expo == '0) ||
              (state == S_INV && waiting && mb_v);
    iw_addr = (state == S_PMUL) ? TMAX : idx - AW'(1);
    iw_data = (state == S_PMUL) ? pacc : mb_r;
  end

  bcmp_mulmod u_mul_build (
    .clk(clk), .rst(rst), .in_valid(mb_go), .a(mb_a), .b(mb_b),
    .out_valid(mb_v), .r(mb_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      waiting <= 1'b0;
      idx     <= '0;
    end else begin
      if (mb_go) waiting <= 1'b1;
      case (state)
        S_INIT: begin
          acc   <= 30'd1;
          idx   <= AW'(1);
          state <= S_FACT;
        end
        S_FACT: begin
          if (waiting && mb_v) begin
            waiting <= 1'b0;
            acc <= mb_r;
            if (idx == TMAX) begin
              base  <= mb_r;
              pacc  <= 30'd1;
              expo  <= PRIME_EXP;
              state <= S_PMUL;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        S_PMUL: begin
          if (!waiting && expo == '0) begin
            acc   <= pacc;
            idx   <= TMAX;
            state <= S_INV;
          end else if (!waiting && !expo[0]) begin
            state <= S_PSQR;
          end else if (waiting && mb_v) begin
            waiting <= 1'b0;
            pacc    <= mb_r;
            state   <= S_PSQR;
          end
        end
        S_PSQR: begin
          if (waiting && mb_v) begin
            waiting <= 1'b0;
            base    <= mb_r;
            expo    <= expo >> 1;
            state   <= S_PMUL;
          end
        end
        S_INV: begin
          if (waiting && mb_v) begin
            waiting <= 1'b0;
            acc <= mb_r;
            if (idx == AW'(1)) begin
              state <= S_DONE;
            end else begin
              idx <= idx - AW'(1);
            end
          end
        end
        default: state <= S_DONE;
      endcase
    end
  end

  // tables: one write port, registered reads
  always_ff @(posedge clk) begin
    if (fw_en) fact_mem[fw_addr] <= fw_data;
    fm_rd <= fact_mem[AW'(q_data.am)];
  end

  always_ff @(posedge clk) begin
    if (iw_en) inv_mem[iw_addr] <= iw_data;
    in_rd <= inv_mem[AW'(q_data.an)];
    id_rd <= inv_mem[AW'(q_data.ad)];
  end

  // query issue, bounded by room left in the output queue
  assign issue = q_valid && (state == S_DONE) && (credit < 5'(OD));
  assign q_ready = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      credit <= '0;
    end else begin
      v0     <= issue;
      credit <= credit + 5'(issue) - 5'(opop);
    end
    f0 <= {q_data.oor, q_data.zero};
    id_dly[0] <= id_rd;
    for (int k = 1; k < MUL_LAT; k++) id_dly[k] <= id_dly[k-1];
    fl_dly[0] <= f0;
    for (int k = 1; k < 2 * MUL_LAT; k++) fl_dly[k] <= fl_dly[k-1];
  end

  bcmp_mulmod u_mul_q1 (
    .clk(clk), .rst(rst), .in_valid(v0), .a(fm_rd), .b(in_rd),
    .out_valid(m1_v), .r(m1_r)
  );

  bcmp_mulmod u_mul_q2 (
    .clk(clk), .rst(rst), .in_valid(m1_v), .a(m1_r), .b(id_dly[MUL_LAT-1]),
    .out_valid(m2_v), .r(m2_r)
  );

  assign fl_out = fl_dly[2*MUL_LAT-1];
  assign m_tvalid = ocount != '0;
  assign opop = m_tvalid & m_tready;
  assign m_tdata = {2'b00, omem[ord][29:0]};
  assign m_tuser = omem[ord][30];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      if (m2_v) owr <= owr + 4'd1;
      if (opop) ord <= ord + 4'd1;
      ocount <= ocount + 5'(m2_v) - 5'(opop);
    end
    if (m2_v) omem[owr] <= {fl_out[1], (fl_out[1] | fl_out[0]) ? 30'd0 : m2_r};
  end

  a_issue_after_build: assert property (@(posedge clk) disable iff (rst)
    issue |-> state == S_DONE) else $error("query issued during table build");
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= 5'(OD) && ocount <= credit) else $error("credit count out of bounds");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    m2_v |-> ocount < 5'(OD)) else $error("output queue overflow");
endmodule

// File: sv/binomial_coefficient_mod_prime.sv
// throughput: one item per cycle once the tables are built and while m_tready drains the output
// after rst the tables are built one step at a time on the single build
// multiplier; items queue meanwhile, then stall
// reset: synchronous, active high, clears all queues and restarts the build
module binomial_coefficient_mod_prime #(
  parameter int unsigned TABLE_MAX = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // top_count [15:0], choose_count [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // coefficient [29:0], zero pad [31:30]
  output logic        m_tuser    // out_of_range
);
  import bcmp_pkg::*;

  // front classifies items into a short queue, back reads tables and multiplies
  logic q_valid;
  logic q_ready;
  qry_t q_data;

  bcmp_front #(.TABLE_MAX(TABLE_MAX)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready)
  );

  // back: factorial build sequencer, two chained modular multipliers,
  // output queue that parts the result side from the issue side
  bcmp_back #(.TABLE_MAX(TABLE_MAX)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );
endmodule
